>>> design/cptd_pkg.sv
package cptd_pkg;

   localparam int TIMER_BITS  = 24;
   localparam int CREDIT_BITS = 16;
   localparam int PULSE_BITS  = 4;
   localparam int VALUE_BITS  = 5;
   localparam int FARE_BITS   = 16;
   localparam int BILL_BITS   = 16;
   localparam int CSR_BITS    = 24;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_ARM  = 2'd1;
   localparam logic [1:0] FUNC_FARE = 2'd2;

   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   localparam logic [CSR_BITS-1:0] DEBOUNCE_RESET = CSR_BITS'(20000);
   localparam logic [CSR_BITS-1:0] TIMEOUT_RESET  = CSR_BITS'(150000);

   typedef struct packed {
      logic [1:0]           func;
      logic                 edge_req;
      logic [FARE_BITS-1:0] fare;
      logic [BILL_BITS-1:0] bill_credit;
   } req_word_type;

   typedef struct packed {
      logic                   coin_done;
      logic                   coin_known;
      logic [VALUE_BITS-1:0]  coin_value;
      logic [PULSE_BITS-1:0]  train_pulses;
      logic [CREDIT_BITS-1:0] credit_total;
      logic                   fare_paid;
      logic                   armed_out;
   } rsp_word_type;

   typedef struct packed {
      logic [TIMER_BITS-1:0]  since_pulse;
      logic [PULSE_BITS-1:0]  pulse_count;
      logic                   in_train;
      logic                   armed;
      logic [CREDIT_BITS-1:0] coin_credit;
   } state_type;

   localparam state_type STATE_RESET = '{
      since_pulse: '1,
      pulse_count: '0,
      in_train:    1'b0,
      armed:       1'b0,
      coin_credit: '0
   };

endpackage

>>> design/cptd_req_if.sv
interface cptd_req_if;
   logic                  valid;
   logic                  ready;
   cptd_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/cptd_rsp_if.sv
interface cptd_rsp_if;
   logic                  valid;
   logic                  ready;
   cptd_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/cptd_step.sv
module cptd_step (
   input  cptd_pkg::state_type                  state,
   input  cptd_pkg::req_word_type               word,
   input  logic [cptd_pkg::CSR_BITS-1:0]        debounce_ticks,
   input  logic [cptd_pkg::CSR_BITS-1:0]        timeout_ticks,
   output cptd_pkg::state_type                  state_next,
   output cptd_pkg::rsp_word_type               result
);

   function automatic logic [cptd_pkg::VALUE_BITS-1:0] coin_value_of(
      input logic [cptd_pkg::PULSE_BITS-1:0] pulses
   );
      logic [cptd_pkg::VALUE_BITS-1:0] v;
      unique case (pulses)
         cptd_pkg::PULSE_BITS'(2): v = cptd_pkg::VALUE_BITS'(10);
         cptd_pkg::PULSE_BITS'(3): v = cptd_pkg::VALUE_BITS'(1);
         cptd_pkg::PULSE_BITS'(4): v = cptd_pkg::VALUE_BITS'(5);
         cptd_pkg::PULSE_BITS'(5): v = cptd_pkg::VALUE_BITS'(20);
         default:                  v = '0;
      endcase
      return v;
   endfunction

   logic [cptd_pkg::TIMER_BITS-1:0]  elapsed;
   logic                             counted;
   logic                             closes;
   logic [cptd_pkg::VALUE_BITS-1:0]  value;
   logic [cptd_pkg::CREDIT_BITS:0]   credit_sum;
   logic [cptd_pkg::CREDIT_BITS-1:0] credit_new;
   logic [cptd_pkg::CREDIT_BITS:0]   fare_sum;
   logic                             paid;

   assign elapsed = (&state.since_pulse) ? state.since_pulse
                                         : state.since_pulse + 1'b1;
   assign counted = state.armed && word.edge_req
                    && (elapsed > cptd_pkg::TIMER_BITS'(debounce_ticks));
   assign closes  = !counted && state.in_train
                    && (elapsed > cptd_pkg::TIMER_BITS'(timeout_ticks));
   assign value   = coin_value_of(state.pulse_count);

   assign credit_sum = {1'b0, state.coin_credit}
                       + (cptd_pkg::CREDIT_BITS + 1)'(value);
   assign credit_new = credit_sum[cptd_pkg::CREDIT_BITS] ? '1
                       : credit_sum[cptd_pkg::CREDIT_BITS-1:0];

   always_comb begin
      state_next = state;
      if (counted) begin
         state_next.since_pulse = '0;
         if (!(&state.pulse_count)) begin
            state_next.pulse_count = state.pulse_count + 1'b1;
         end
         state_next.in_train = 1'b1;
      end else begin
         state_next.since_pulse = elapsed;
         if (closes) begin
            state_next.pulse_count = '0;
            state_next.in_train    = 1'b0;
            state_next.coin_credit = credit_new;
         end
      end
      fare_sum = (cptd_pkg::CREDIT_BITS + 1)'(word.bill_credit)
                 + (cptd_pkg::CREDIT_BITS + 1)'(state_next.coin_credit);
      paid = 1'b0;
      priority if (word.func == cptd_pkg::FUNC_ARM) begin
         state_next.armed = 1'b1;
      end else if (word.func == cptd_pkg::FUNC_FARE) begin
         if (fare_sum >= (cptd_pkg::CREDIT_BITS + 1)'(word.fare)) begin
            state_next.armed = 1'b0;
            paid = 1'b1;
         end
      end else begin
         state_next.armed = state.armed;
      end
   end

   always_comb begin
      result.coin_done    = closes;
      result.coin_known   = closes && (value != '0);
      result.coin_value   = closes ? value : '0;
      result.train_pulses = closes ? state.pulse_count : '0;
      result.credit_total = state_next.coin_credit;
      result.fare_paid    = paid;
      result.armed_out    = state_next.armed;
   end

endmodule

>>> design/coin_pulse_train_decoder.sv
// channel  direction  word             handshake
// req      in         func/edge/fare   valid && ready
// rsp      out        coin result      valid && ready
// csr      in         index/data       write enable, no wait
//
// one word per cycle while req is ready: the state update is a single registered pass
// an accepted result is registered in the output register, or in the second buffer entry behind a held word
// a two-entry output buffer keeps req ready for one word while rsp stalls
// synchronous active-high reset restores the register defaults and loads STATE_RESET into the state
module coin_pulse_train_decoder (
   input  logic                          clock,
   input  logic                          reset,
   cptd_req_if.sink                      req_bus,
   cptd_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [cptd_pkg::CSR_BITS-1:0] csr_write_data
);

   cptd_pkg::state_type              state_ff, state_in;
   cptd_pkg::rsp_word_type           result;
   logic [cptd_pkg::CSR_BITS-1:0]    debounce_ff, timeout_ff;
   cptd_pkg::rsp_word_type           out_ff, out_in, skid_ff, skid_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             skid_valid_ff, skid_valid_in;
   logic                             accept, take;

   cptd_step u_step (
      .state          (state_ff),
      .word           (req_bus.data),
      .debounce_ticks (debounce_ff),
      .timeout_ticks  (timeout_ff),
      .state_next     (state_in),
      .result         (result)
   );

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign take          = out_valid_ff && rsp_bus.ready;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = result;
            skid_valid_in = accept;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cptd_pkg::STATE_RESET;
         debounce_ff   <= cptd_pkg::DEBOUNCE_RESET;
         timeout_ff    <= cptd_pkg::TIMEOUT_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               cptd_pkg::CSR_DEBOUNCE: debounce_ff <= csr_write_data;
               cptd_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_write_data;
               default:                debounce_ff <= debounce_ff;
            endcase
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output word");

   a_idle_train_empty: assert property (@(posedge clock) disable iff (reset)
      !state_ff.in_train |-> (state_ff.pulse_count == '0))
      else $error("pulse count left over outside a train");

   a_no_train_no_coin: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.data.coin_done) |->
      (!rsp_bus.data.coin_known && rsp_bus.data.coin_value == '0
       && rsp_bus.data.train_pulses == '0))
      else $error("coin fields set without a closed train");

   a_stall_accept_skids: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready && accept) |=> skid_valid_ff)
      else $error("word accepted under stall was not buffered");

endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cptd_pkg::*;

   localparam logic [1:0]          FUNC_SPARE      = 2'd3;
   localparam int                  CYCLE_LIMIT     = 400000;
   localparam int                  GAP_CAP         = 30;
   localparam int                  TOP_COIN_PULSES = 5;
   localparam logic [CSR_BITS-1:0] TICKS_MAX       = '1;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic                csr_index;
   logic [CSR_BITS-1:0] csr_write_data;

   cptd_req_if req_bus ();
   cptd_rsp_if rsp_bus ();

   coin_pulse_train_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   state_type           model_state;
   logic [CSR_BITS-1:0] debounce_set;
   logic [CSR_BITS-1:0] timeout_set;

   req_word_type words_to_send[$];
   rsp_word_type results_due[$];
   int unsigned  words_queued;
   int unsigned  words_taken;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           failures;
   int           cycle_count;

   function automatic rsp_word_type decode_word(input req_word_type w);
      rsp_word_type          r;
      logic [TIMER_BITS-1:0] elapsed;
      logic [VALUE_BITS-1:0] value;
      logic [CREDIT_BITS:0]  sum;
      r = '0;
      value = '0;
      elapsed = (&model_state.since_pulse) ? model_state.since_pulse
                                           : model_state.since_pulse + 1'b1;
      if (model_state.armed && w.edge_req && elapsed > debounce_set) begin
         model_state.since_pulse = '0;
         if (~&model_state.pulse_count) model_state.pulse_count += 1'b1;
         model_state.in_train = 1'b1;
      end else begin
         model_state.since_pulse = elapsed;
         if (model_state.in_train && elapsed > timeout_set) begin
            case (model_state.pulse_count)
               4'd2: begin
                  value = 5'd10;
               end
               4'd3: begin
                  value = 5'd1;
               end
               4'd4: begin
                  value = 5'd5;
               end
               4'd5: begin
                  value = 5'd20;
               end
               default: begin
                  value = '0;
               end
            endcase
            r.coin_done    = 1'b1;
            r.coin_known   = (value != '0);
            r.coin_value   = value;
            r.train_pulses = model_state.pulse_count;
            sum = {1'b0, model_state.coin_credit} + value;
            model_state.coin_credit = sum[CREDIT_BITS] ? '1 : sum[CREDIT_BITS-1:0];
            model_state.pulse_count = '0;
            model_state.in_train    = 1'b0;
         end
      end
      if (w.func == FUNC_ARM) begin
         model_state.armed = 1'b1;
      end else if (w.func == FUNC_FARE) begin
         if (32'(w.bill_credit) + 32'(model_state.coin_credit) >= 32'(w.fare)) begin
            model_state.armed = 1'b0;
            r.fare_paid = 1'b1;
         end
      end
      r.credit_total = model_state.coin_credit;
      r.armed_out    = model_state.armed;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic int unsigned capped(input logic [CSR_BITS-1:0] ticks);
      return (ticks > GAP_CAP) ? GAP_CAP : int'(ticks);
   endfunction

   task automatic add_word(input logic [1:0] func, input logic edge_bit,
                           input logic [FARE_BITS-1:0] fare,
                           input logic [BILL_BITS-1:0] bill);
      req_word_type w;
      w.func        = func;
      w.edge_req    = edge_bit;
      w.fare        = fare;
      w.bill_credit = bill;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic add_pulses(input int unsigned count);
      repeat (count) add_word(FUNC_TICK, 1'b1, $urandom, $urandom);
   endtask

   task automatic add_fare_check();
      if ($urandom_range(0, 1)) begin
         add_word(FUNC_FARE, $urandom_range(0, 1), $urandom_range(0, 60),
                  $urandom_range(0, 30));
      end else begin
         add_word(FUNC_FARE, $urandom_range(0, 1), $urandom, $urandom);
      end
   endtask

   task automatic add_random_stretch(input int unsigned count);
      int unsigned start_mark;
      int unsigned pulses;
      int unsigned gap;
      int unsigned hush;
      int unsigned silence;
      int unsigned i;
      start_mark = words_queued;
      while (words_queued - start_mark < count) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               add_word($urandom_range(0, 3), $urandom_range(0, 1), $urandom, $urandom);
            end
         end else begin
            if ($urandom_range(0, 9) < 8) begin
               add_word(FUNC_ARM, $urandom_range(0, 1), $urandom, $urandom);
            end
            pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18)
                                                 : $urandom_range(1, 6);
            repeat (pulses) begin
               add_word(FUNC_TICK, 1'b1, $urandom, $urandom);
               gap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, capped(debounce_set))
                                                 : capped(debounce_set) + $urandom_range(0, 2);
               repeat (gap) begin
                  if ($urandom_range(0, 11) == 0) begin
                     add_fare_check();
                  end else begin
                     add_word(FUNC_TICK, $urandom_range(0, 9) == 0, $urandom, $urandom);
                  end
               end
            end
            hush = capped(timeout_set) + 1;
            silence = hush + $urandom_range(0, 2);
            for (i = 1; i <= silence; i++) begin
               if (i == hush && $urandom_range(0, 2) == 0) begin
                  add_fare_check();
               end else begin
                  add_word(FUNC_TICK, 1'b0, $urandom, $urandom);
               end
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_phase(input logic [CSR_BITS-1:0] debounce,
                            input logic [CSR_BITS-1:0] timeout,
                            input int send_pct, input int recv_pct);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_DEBOUNCE;
      csr_write_data <= debounce;
      @(posedge clock);
      csr_index      <= CSR_TIMEOUT;
      csr_write_data <= timeout;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      debounce_set  = debounce;
      timeout_set   = timeout;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // driver: word taken when valid and ready were both high before this edge
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            results_due.push_back(decode_word(req_bus.data));
            words_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.data  <= words_to_send.pop_front();
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               $error("result word arrived with none due");
               failures++;
            end else begin
               want = results_due.pop_front();
               check_field("coin_done", want.coin_done, rsp_bus.data.coin_done);
               check_field("coin_known", want.coin_known, rsp_bus.data.coin_known);
               check_field("coin_value", want.coin_value, rsp_bus.data.coin_value);
               check_field("train_pulses", want.train_pulses, rsp_bus.data.train_pulses);
               check_field("credit_total", want.credit_total, rsp_bus.data.credit_total);
               check_field("fare_paid", want.fare_paid, rsp_bus.data.fare_paid);
               check_field("armed_out", want.armed_out, rsp_bus.data.armed_out);
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_DEBOUNCE;
      csr_write_data = '0;
      req_bus.valid  = 1'b0;
      req_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      model_state    = STATE_RESET;
      debounce_set   = DEBOUNCE_RESET;
      timeout_set    = TIMEOUT_RESET;
      words_queued   = 0;
      words_taken    = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      failures       = 0;
      cycle_count    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // disarmed edges, spare func, re-arm, edge blocked by saturated counter
      set_phase(TICKS_MAX, TIMEOUT_RESET, 13, 67);
      add_word(FUNC_FARE, 1'b0, '0, '0);
      add_word(FUNC_TICK, 1'b1, '1, '1);
      add_word(FUNC_SPARE, 1'b1, '0, '0);
      add_word(FUNC_ARM, 1'b0, '0, '0);
      add_word(FUNC_ARM, 1'b1, '0, '0);

      // a repeat edge lands inside debounce, then failed and paid fare at the top
      set_phase(DEBOUNCE_RESET, TIMEOUT_RESET, 13, 67);
      add_pulses(2);
      add_word(FUNC_FARE, 1'b0, '1, 16'hFFFE);
      add_word(FUNC_FARE, 1'b0, '1, '1);

      // lone pulse closes while disarmed, then each coin, one fare on closing word
      set_phase('0, '0, 13, 67);
      add_word(FUNC_ARM, 1'b0, '0, '0);
      add_pulses(2);
      add_word(FUNC_TICK, 1'b0, '0, '0);
      add_pulses(3);
      add_word(FUNC_FARE, 1'b0, 16'd11, '0);
      add_word(FUNC_ARM, 1'b0, '0, '0);
      add_pulses(4);
      add_word(FUNC_TICK, 1'b0, '0, '0);
      add_pulses(5);
      add_word(FUNC_TICK, 1'b0, '0, '0);

      set_phase(24'd1, 24'd4, 13, 67);
      add_random_stretch(240);
      set_phase('0, TICKS_MAX, 13, 67);
      add_random_stretch(70);
      set_phase(24'd4, 24'd9, 13, 67);
      add_random_stretch(180);
      set_phase(TICKS_MAX, 24'd6, 67, 13);
      add_random_stretch(70);
      set_phase(24'd2, 24'd7, 67, 13);
      add_random_stretch(240);
      set_phase('0, 24'd2, 0, 0);
      add_random_stretch(240);
      set_phase(24'd6, 24'd20, 0, 0);
      add_random_stretch(160);

      // top coin trains back to back
      set_phase('0, '0, 0, 0);
      add_word(FUNC_ARM, 1'b0, '0, '0);
      repeat (4) begin
         add_pulses(TOP_COIN_PULSES);
         add_word(FUNC_TICK, 1'b0, $urandom, $urandom);
      end
      add_word(FUNC_FARE, 1'b0, '1, '0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
